// ===== design/urd_pkg.sv =====
// ----------------------------------------------------------------------------
// urd_pkg: shared types and defaults for the unsigned restoring divider
// Holds the default operand width and the per-stage control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package urd_pkg;

  // Default operand width in bits
  localparam int unsigned DefDataWidth = 32;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;     // stage holds an item
    logic div_zero;  // divisor of this item was zero
  } urd_ctrl_t;

endpackage

`default_nettype wire

// ===== design/urd_stage.sv =====
// ----------------------------------------------------------------------------
// urd_stage: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the new quotient bit into the low end of
// the dividend word. Registers the result when the pipeline advances.
// ----------------------------------------------------------------------------
`default_nettype none

module urd_stage
  import urd_pkg::*;
#(
  parameter int unsigned DataWidth = DefDataWidth
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire urd_ctrl_t            ctrl_i,
  input  wire logic [DataWidth-1:0] rem_i,
  input  wire logic [DataWidth-1:0] nq_i,   // dividend bits left, quotient bits below
  input  wire logic [DataWidth-1:0] den_i,
  output urd_ctrl_t                 ctrl_o,
  output logic      [DataWidth-1:0] rem_o,
  output logic      [DataWidth-1:0] nq_o,
  output logic      [DataWidth-1:0] den_o
);

  urd_ctrl_t              ctrl_q;
  logic [DataWidth-1:0]   rem_d, rem_q;
  logic [DataWidth-1:0]   nq_d, nq_q;
  logic [DataWidth-1:0]   den_q;
  logic [DataWidth:0]     trial;
  logic [DataWidth:0]     diff;
  logic                   take;

  // Partial remainder with the bit shifted out kept on top
  assign trial = {rem_i, nq_i[DataWidth-1]};
  assign diff  = trial - {1'b0, den_i};
  // No borrow means the divisor fits
  assign take  = ~diff[DataWidth];

  always_comb begin
    rem_d = take ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
    nq_d  = {nq_i[DataWidth-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      den_q <= den_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign nq_o   = nq_q;
  assign den_o  = den_q;

endmodule

`default_nettype wire

// ===== design/unsigned_restoring_divider_unit.sv =====
// Pipeline: one registered stage per quotient bit between input transfer and result
// valid, one subtract and compare per stage.
// Throughput: one division per cycle; the whole pipeline holds while a result
// waits at the output and the next item still enters if the output is taken.
// Reset: asynchronous, active low; clears all stage valid bits.
// ----------------------------------------------------------------------------
// unsigned_restoring_divider_unit: pipelined unsigned restoring divider
// Radix-2 restoring division, one quotient bit per pipeline stage. A zero
// divisor gives zero quotient and remainder and raises the flag in tuser.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_restoring_divider_unit
  import urd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DefDataWidth,
  localparam int unsigned TdataWidth = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [TdataWidth-1:0] s_axis_tdata,  // dividend, divisor
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [TdataWidth-1:0] m_axis_tdata,  // quotient, remainder
  output logic                       m_axis_tuser   // divided_by_zero
);

  urd_ctrl_t              ctrl  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]  rem   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]  nq    [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]  den   [DATA_WIDTH+1];
  logic                   adv;
  logic [DATA_WIDTH-1:0]  quo_out;
  logic [DATA_WIDTH-1:0]  rem_out;

  // Advance everything unless a finished result is held at the output
  assign adv           = m_axis_tready | ~ctrl[DATA_WIDTH].valid;
  assign s_axis_tready = adv;

  assign ctrl[0].valid    = s_axis_tvalid;
  assign ctrl[0].div_zero = (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH] == '0);
  assign rem[0]           = '0;
  assign nq[0]            = s_axis_tdata[DATA_WIDTH-1:0];
  assign den[0]           = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
    urd_stage #(
      .DataWidth(DATA_WIDTH)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .ctrl_i(ctrl[k]),
      .rem_i (rem[k]),
      .nq_i  (nq[k]),
      .den_i (den[k]),
      .ctrl_o(ctrl[k+1]),
      .rem_o (rem[k+1]),
      .nq_o  (nq[k+1]),
      .den_o (den[k+1])
    );
  end

  // Zero divisor: drop the raw step results
  assign quo_out = ctrl[DATA_WIDTH].div_zero ? '0 : nq[DATA_WIDTH];
  assign rem_out = ctrl[DATA_WIDTH].div_zero ? '0 : rem[DATA_WIDTH];

  assign m_axis_tvalid = ctrl[DATA_WIDTH].valid;
  assign m_axis_tdata  = TdataWidth'({rem_out, quo_out});
  assign m_axis_tuser  = ctrl[DATA_WIDTH].div_zero;

endmodule

`default_nettype wire
